FILE: src/pffl_pkg.sv
package pffl_pkg;

   // Request command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] RSP_GRANT = 2'd0;
   localparam logic [1:0] RSP_SHORT = 2'd1;
   localparam logic [1:0] RSP_FREED = 2'd2;

   // Register index carried on csr_paddr[2]
   localparam logic CSR_FREE_REGION_BASE = 1'b0;

   typedef enum logic [2:0] {
      CS_INIT,
      CS_IDLE,
      CS_CHECK,
      CS_EMIT,
      CS_SHORT,
      CS_WALK,
      CS_FREED
   } ctl_state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_LINK,
      RD_CHAIN
   } rd_sel_type;

   typedef enum logic [2:0] {
      REM_HOLD,
      REM_ZERO,
      REM_REQ,
      REM_N,
      REM_DEC
   } rem_op_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_GRANT,
      OUT_SHORT,
      OUT_FREED
   } out_kind_type;

   typedef struct packed {
      logic         init_wr;
      logic         take_req;
      logic         rd_en;
      rd_sel_type   rd_sel;
      rem_op_type   rem_op;
      logic         step_clr;
      logic         step_inc;
      out_kind_type out_kind;
      logic         alloc_finish;
      logic         free_splice;
   } dp_cmd_type;

   typedef struct packed {
      logic init_last;
      logic req_n_bad;
      logic req_n_one;
      logic req_chain_oob;
      logic rd_valid;
      logic rem_zero;
      logic rem_one;
      logic step_last;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: src/page_frame_free_list_allocator_top.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  command, page_count, chain_head
// rsp_      out        rsp_valid/rsp_ready  status, frame_index, physical_address, last
// csr_      in/out     APB, pready tied 1   free_region_base at byte address 0
//
// Sequence: an allocate of n frames checks n-1 links of the run, then emits n
// grants; one turned away up front, or found short, emits one short result.
// A free walks its chain to the tail, then emits one freed result; a chain that never ends is left alone.
// Reset: a FRAME_COUNT-cycle sweep rebuilds the in-order list before the
// first transaction is accepted; CSR writes are taken throughout.
// Stalls: a held rsp_ready freezes the walk at the next result; one output register.
module page_frame_free_list_allocator_top #(
   parameter int FRAME_COUNT = 128,
   parameter int MAX_RUN     = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [6:0]  req_page_count,
   input  logic [6:0]  req_chain_head,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_frame_index,
   output logic [31:0] rsp_physical_address,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pffl_pkg::*;

   logic [31:0] base_ff, base_in;
   // base rounded up to 4 KiB, kept as its page number
   logic [19:0] base_hi_ff, base_hi_in;
   logic        csr_wr;

   dp_cmd_type  cmd;
   dp_sts_type  sts;

   // Register write lands on the access phase; anything above register 0 drops.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FREE_REGION_BASE) ? base_ff : 32'd0;

   always_comb begin
      base_in    = base_ff;
      base_hi_in = base_hi_ff;
      if (csr_wr && csr_paddr[2] == CSR_FREE_REGION_BASE) begin
         base_in    = csr_pwdata;
         // round up: advance the page number when any offset bit is set, wrap at 2^32
         base_hi_in = csr_pwdata[31:12] + 20'(|csr_pwdata[11:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= 32'd0;
         base_hi_ff <= 20'd0;
      end else begin
         base_ff    <= base_in;
         base_hi_ff <= base_hi_in;
      end
   end

   // Sequencer: decides each cycle which link to read and what to emit.
   pffl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Link store, head pointer, walk counters and the output register.
   pffl_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .MAX_RUN     (MAX_RUN)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_page_count       (req_page_count),
      .req_chain_head       (req_chain_head),
      .base_hi              (base_hi_ff),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_frame_index      (rsp_frame_index),
      .rsp_physical_address (rsp_physical_address),
      .rsp_last             (rsp_last)
   );

endmodule

FILE: src/pffl_ctrl.sv
module pffl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_command,
   output logic                req_ready,
   input  pffl_pkg::dp_sts_type sts,
   output pffl_pkg::dp_cmd_type cmd
);
   import pffl_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd              = '0;
      cmd.rd_sel       = RD_HEAD;
      cmd.rem_op       = REM_HOLD;
      cmd.out_kind     = OUT_NONE;
      unique case (state_ff)
         CS_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.init_last) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               if (req_command == CMD_ALLOC) begin
                  if (sts.req_n_bad) begin
                     state_in = CS_SHORT;
                  end else if (sts.req_n_one) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_HEAD;
                     cmd.rem_op = REM_ZERO;
                     state_in   = CS_EMIT;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_HEAD;
                     cmd.rem_op = REM_REQ;
                     state_in   = CS_CHECK;
                  end
               end else begin
                  if (sts.req_chain_oob) begin
                     state_in = CS_FREED;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = RD_CHAIN;
                     cmd.step_clr = 1'b1;
                     state_in     = CS_WALK;
                  end
               end
            end
         end
         CS_CHECK: begin
            // confirm the run is there before touching the list
            if (!sts.rd_valid) begin
               state_in = CS_SHORT;
            end else if (sts.rem_one) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HEAD;
               cmd.rem_op = REM_N;
               state_in   = CS_EMIT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LINK;
               cmd.rem_op = REM_DEC;
            end
         end
         CS_EMIT: begin
            if (sts.out_free) begin
               cmd.out_kind = OUT_GRANT;
               if (sts.rem_zero) begin
                  cmd.alloc_finish = 1'b1;
                  state_in         = CS_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LINK;
                  cmd.rem_op = REM_DEC;
               end
            end
         end
         CS_SHORT: begin
            if (sts.out_free) begin
               cmd.out_kind = OUT_SHORT;
               state_in     = CS_IDLE;
            end
         end
         CS_WALK: begin
            if (!sts.rd_valid) begin
               cmd.free_splice = 1'b1;
               state_in        = CS_FREED;
            end else if (sts.step_last) begin
               // chain never ends: drop the free
               state_in = CS_FREED;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = RD_LINK;
               cmd.step_inc = 1'b1;
            end
         end
         CS_FREED: begin
            if (sts.out_free) begin
               cmd.out_kind = OUT_FREED;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_INIT;
         end
      endcase
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_kind != OUT_NONE) |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_wr, cmd.alloc_finish, cmd.free_splice}))
      else $error("two link store writes in one cycle");

   a_checked_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_EMIT && !sts.rem_zero) |-> sts.rd_valid)
      else $error("granted run breaks after the check pass");

   a_init_done: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == CS_INIT && state_ff == CS_IDLE) |-> $past(sts.init_last))
      else $error("left init sweep early");

endmodule

FILE: src/pffl_datapath.sv
module pffl_datapath #(
   parameter int FRAME_COUNT = 128,
   parameter int MAX_RUN     = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           req_page_count,
   input  logic [6:0]           req_chain_head,
   input  logic [19:0]          base_hi,
   input  pffl_pkg::dp_cmd_type cmd,
   output pffl_pkg::dp_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [6:0]           rsp_frame_index,
   output logic [31:0]          rsp_physical_address,
   output logic                 rsp_last
);
   import pffl_pkg::*;

   localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_COUNT - 1);

   // link store: {valid, next index}
   logic [IW:0]   link_mem [FRAME_COUNT];
   logic [IW:0]   rd_data_ff;
   logic          rd_valid;
   logic [IW-1:0] rd_link;
   logic [IW-1:0] rd_addr;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW:0]   wr_data;

   logic [IW-1:0] init_ff, init_in;
   logic [IW-1:0] head_ff, head_in;
   logic          head_valid_ff, head_valid_in;
   logic [IW-1:0] cur_ff;
   logic [IW-1:0] step_ff, step_in;
   logic [6:0]    rem_ff, rem_in;
   logic [6:0]    n_ff;
   logic [6:0]    chain_ff;
   logic [6:0]    req_n;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff;
   logic [6:0]    index_ff;
   logic [31:0]   addr_ff;
   logic          last_ff;

   assign rd_valid = rd_data_ff[IW];
   assign rd_link  = rd_data_ff[IW-1:0];
   assign req_n    = (req_page_count == 7'd0) ? 7'd1 : req_page_count;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD:  rd_addr = head_ff;
         RD_LINK:  rd_addr = rd_link;
         RD_CHAIN: rd_addr = IW'(req_chain_head);
         default:  rd_addr = head_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = '0;
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_addr = init_ff;
         wr_data = (init_ff == LAST_IDX) ? '0 : {1'b1, init_ff + IW'(1)};
      end else if (cmd.alloc_finish) begin
         wr_en = 1'b1;
      end else if (cmd.free_splice) begin
         wr_en   = 1'b1;
         wr_data = {head_valid_ff, head_valid_ff ? head_ff : IW'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
         cur_ff     <= rd_addr;
      end
   end

   always_comb begin
      init_in       = cmd.init_wr ? init_ff + IW'(1) : init_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      if (cmd.alloc_finish) begin
         head_in       = rd_valid ? rd_link : IW'(0);
         head_valid_in = rd_valid;
      end else if (cmd.free_splice) begin
         head_in       = IW'(chain_ff);
         head_valid_in = 1'b1;
      end
      step_in = step_ff;
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + IW'(1);
      end
      unique case (cmd.rem_op)
         REM_HOLD: rem_in = rem_ff;
         REM_ZERO: rem_in = 7'd0;
         REM_REQ:  rem_in = req_n - 7'd1;
         REM_N:    rem_in = n_ff - 7'd1;
         REM_DEC:  rem_in = rem_ff - 7'd1;
         default:  rem_in = rem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff       <= '0;
         head_ff       <= '0;
         head_valid_ff <= 1'b1;
         step_ff       <= '0;
         rem_ff        <= '0;
      end else begin
         init_ff       <= init_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         step_ff       <= step_in;
         rem_ff        <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         n_ff     <= req_n;
         chain_ff <= req_chain_head;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_kind != OUT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.out_kind)
         OUT_NONE: begin
         end
         OUT_GRANT: begin
            status_ff <= RSP_GRANT;
            index_ff  <= 7'(cur_ff);
            addr_ff   <= {base_hi + 20'(cur_ff), 12'h000};
            last_ff   <= (rem_ff == 7'd0);
         end
         OUT_SHORT: begin
            status_ff <= RSP_SHORT;
            index_ff  <= 7'd0;
            addr_ff   <= 32'd0;
            last_ff   <= 1'b1;
         end
         OUT_FREED: begin
            status_ff <= RSP_FREED;
            index_ff  <= 7'd0;
            addr_ff   <= 32'd0;
            last_ff   <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_frame_index      = index_ff;
   assign rsp_physical_address = addr_ff;
   assign rsp_last             = last_ff;

   assign sts.init_last     = (init_ff == LAST_IDX);
   assign sts.req_n_bad     = (req_n > 7'(MAX_RUN)) || !head_valid_ff;
   assign sts.req_n_one     = (req_n == 7'd1);
   assign sts.req_chain_oob = (32'(req_chain_head) >= 32'(FRAME_COUNT));
   assign sts.rd_valid      = rd_valid;
   assign sts.rem_zero      = (rem_ff == 7'd0);
   assign sts.rem_one       = (rem_ff == 7'd1);
   assign sts.step_last     = (step_ff == LAST_IDX);
   assign sts.out_free      = !rsp_valid_ff || rsp_ready;

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pffl_pkg::*;

   localparam int FRAMES       = 128;
   localparam int RUN_LIMIT    = 64;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 114;   // per random phase, four phases

   typedef struct packed {
      logic       command;
      logic [6:0] page_count;
      logic [6:0] chain_head;
   } frame_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  frame_index;
      logic [31:0] physical_address;
      logic        last;
   } frame_result_type;

   // DUT ports; every input starts at a known value
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_command    = CMD_ALLOC;
   logic [6:0]  req_page_count = '0;
   logic [6:0]  req_chain_head = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_frame_index;
   logic [31:0] rsp_physical_address;
   logic        rsp_last;
   logic        csr_psel       = 1'b0;
   logic        csr_penable    = 1'b0;
   logic        csr_pwrite     = 1'b0;
   logic [2:0]  csr_paddr      = '0;
   logic [31:0] csr_pwdata     = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the free list: one link and one valid bit per frame,
   // plus the head pointer and the region base register.
   logic [6:0]  link_next [FRAMES];
   logic        link_ok   [FRAMES];
   logic [6:0]  head_frame;
   logic        head_ok;
   logic [31:0] region_base;

   frame_request_type pending_requests [$];
   frame_result_type  expected_grants  [$];
   int                allocated_chains [$];   // heads of runs handed out, not yet freed

   int sent_cnt    = 0;
   int queued_cnt  = 0;
   int error_cnt   = 0;
   int cycle_cnt   = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit track_chains = 1'b0;

   // Neither side stalls at random while this stretch of transactions passes
   logic calm_stretch;
   assign calm_stretch = (sent_cnt >= 260) && (sent_cnt < 340);

   page_frame_free_list_allocator_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_page_count       (req_page_count),
      .req_chain_head       (req_chain_head),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_frame_index      (rsp_frame_index),
      .rsp_physical_address (rsp_physical_address),
      .rsp_last             (rsp_last),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
         error_cnt++;
      end
   endfunction

   // Round the base up to a 4 KiB boundary, then add the frame offset; both wrap at 2^32
   function automatic logic [31:0] frame_address(input int unsigned frame);
      logic [31:0] base;
      base = (region_base + 32'hFFF) & ~32'hFFF;
      return base + frame * 32'h1000;
   endfunction

   function automatic void expect_result(input logic [1:0] status, input logic [6:0] frame,
                                         input logic [31:0] addr, input logic last);
      frame_result_type r;
      r.status           = status;
      r.frame_index      = frame;
      r.physical_address = addr;
      r.last             = last;
      expected_grants.push_back(r);
   endfunction

   // Apply one accepted transaction to the shadow list and queue the results it causes
   task automatic track_free_list(input frame_request_type item);
      int         run_len;
      int         steps;
      int         i;
      logic [6:0] cur;
      if (item.command == CMD_ALLOC) begin
         run_len = (item.page_count == 0) ? 1 : int'(item.page_count);
         if (run_len > RUN_LIMIT || !head_ok) begin
            expect_result(RSP_SHORT, '0, '0, 1'b1);
            return;
         end
         // Make sure the run fits before touching the list
         cur = head_frame;
         for (i = 1; i < run_len; i++) begin
            if (!link_ok[cur]) begin
               expect_result(RSP_SHORT, '0, '0, 1'b1);
               return;
            end
            cur = link_next[cur];
         end
         if (track_chains)
            allocated_chains.push_back(int'(head_frame));
         cur = head_frame;
         for (i = 0; i < run_len; i++) begin
            expect_result(RSP_GRANT, cur, frame_address(32'(cur)), i == run_len - 1);
            if (i == run_len - 1) begin
               head_ok         = link_ok[cur];
               head_frame      = link_ok[cur] ? link_next[cur] : '0;
               link_ok[cur]    = 1'b0;
               link_next[cur]  = '0;
            end else begin
               cur = link_next[cur];
            end
         end
      end else begin
         expect_result(RSP_FREED, '0, '0, 1'b1);
         // chain_head is 7 bits wide, so it is always inside the frame range.
         // Walk to the tail; a walk that never ends leaves the list alone.
         cur   = item.chain_head;
         steps = 0;
         while (link_ok[cur]) begin
            steps++;
            if (steps >= FRAMES)
               return;
            cur = link_next[cur];
         end
         link_ok[cur]   = head_ok;
         link_next[cur] = head_ok ? head_frame : '0;
         head_frame     = item.chain_head;
         head_ok        = 1'b1;
      end
   endtask

   function automatic int free_list_length();
      int         n;
      logic [6:0] cur;
      if (!head_ok)
         return 0;
      n   = 1;
      cur = head_frame;
      while (link_ok[cur] && n < FRAMES) begin
         cur = link_next[cur];
         n++;
      end
      return n;
   endfunction

   // Mostly well-formed traffic: allocate runs, free chains that were handed out.
   // With noise on, also free arbitrary frames (double frees, partial chains).
   function automatic frame_request_type next_random_request(input bit with_noise);
      frame_request_type item;
      int                avail;
      int                pick;
      int                roll;
      int                count;
      avail           = free_list_length();
      roll            = $urandom_range(99);
      item.command    = CMD_ALLOC;
      item.page_count = 7'($urandom_range(127));
      item.chain_head = 7'($urandom_range(127));
      if (with_noise && roll < 8) begin
         item.command = CMD_FREE;
         return item;
      end
      if (allocated_chains.size() != 0 && (roll < 35 || (avail < 16 && roll < 75))) begin
         pick            = $urandom_range(allocated_chains.size() - 1);
         item.command    = CMD_FREE;
         item.chain_head = 7'(allocated_chains[pick]);
         allocated_chains.delete(pick);
         return item;
      end
      roll = $urandom_range(99);
      if (roll < 65)
         count = $urandom_range(8);
      else if (roll < 85)
         count = $urandom_range(RUN_LIMIT, 9);
      else if (roll < 95) begin
         // land exactly on the end of the list, or one past it
         count = avail + $urandom_range(1);
         if (count > 127)
            count = 127;
      end else
         count = $urandom_range(127, RUN_LIMIT + 1);
      item.page_count = 7'(count);
      return item;
   endfunction

   function automatic void queue_request(input logic command, input int count, input int chain);
      frame_request_type item;
      item.command    = command;
      item.page_count = 7'(count);
      item.chain_head = 7'(chain);
      pending_requests.push_back(item);
      queued_cnt++;
   endfunction

   // APB write of the region base, then read it back during a second access
   task automatic write_region_base(input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_FREE_REGION_BASE, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      region_base = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      check_field("free_region_base readback", value, csr_prdata);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Request driver: present the next pending transaction, hold it until accepted
   always @(posedge clock) begin
      frame_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_free_list({req_command, req_page_count, req_chain_head});
            sent_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && (calm_stretch || $urandom_range(99) >= 13)) begin
               item           = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_command    <= item.command;
               req_page_count <= item.page_count;
               req_chain_head <= item.chain_head;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transaction with the oldest expectation,
   // stall at random, and hold off once for a long stretch to back up the block
   always @(posedge clock) begin
      frame_result_type seen;
      frame_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_status, rsp_frame_index, rsp_physical_address, rsp_last};
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d frame %0d",
                        $time, seen.status, seen.frame_index);
               error_cnt++;
            end else begin
               want = expected_grants.pop_front();
               check_field("status", 32'(want.status), 32'(seen.status));
               check_field("frame_index", 32'(want.frame_index), 32'(seen.frame_index));
               check_field("physical_address", want.physical_address, seen.physical_address);
               check_field("last", 32'(want.last), 32'(seen.last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && sent_cnt >= 150) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         rsp_ready <= (hold_left == 0) && (calm_stretch || $urandom_range(99) >= 13);
      end
   end

   initial begin
      int          k;
      int          phase;
      logic [31:0] phase_base [4];

      // Shadow list after reset: 0 -> 1 -> ... -> 127, tail null
      for (k = 0; k < FRAMES; k++) begin
         link_ok[k]   = (k + 1 < FRAMES);
         link_next[k] = (k + 1 < FRAMES) ? 7'(k + 1) : '0;
      end
      head_frame  = '0;
      head_ok     = 1'b1;
      region_base = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, base near the top so addresses wrap
      write_region_base(32'hFFFF_F000);
      queue_request(CMD_ALLOC, 0, 0);      // count of zero grants frame 0
      queue_request(CMD_ALLOC, 127, 0);    // over the run limit
      queue_request(CMD_ALLOC, 65, 0);     // just over the run limit
      queue_request(CMD_ALLOC, 64, 0);     // frames 1..64
      queue_request(CMD_ALLOC, 64, 0);     // only 63 left: too short
      queue_request(CMD_ALLOC, 63, 0);     // frames 65..127, list empty
      queue_request(CMD_ALLOC, 1, 0);      // empty list
      queue_request(CMD_ALLOC, 0, 127);    // empty list
      queue_request(CMD_FREE, 127, 1);     // give back 1..64
      queue_request(CMD_FREE, 0, 65);      // give back 65..127
      queue_request(CMD_FREE, 0, 0);       // give back frame 0, list full
      queue_request(CMD_FREE, 0, 0);       // double free closes a loop
      queue_request(CMD_FREE, 0, 127);     // walk never ends: ignored
      queue_request(CMD_ALLOC, 64, 0);     // breaks the loop at frame 127
      queue_request(CMD_ALLOC, 64, 0);     // frames 1..64, leaves 0,65..127
      queue_request(CMD_FREE, 0, 1);       // list full and sane again
      wait (sent_cnt == queued_cnt && expected_grants.size() == 0);

      // Random phases, one base setting each; stray frees only in the last
      phase_base[0] = 32'h0000_0000;
      phase_base[1] = 32'hFFFF_FFFF;
      phase_base[2] = $urandom();
      phase_base[3] = 32'h7FFF_F001;
      track_chains  = 1'b1;
      for (phase = 0; phase < 4; phase++) begin
         write_region_base(phase_base[phase]);
         for (k = 0; k < RANDOM_ITEMS; k++) begin
            // generate only once the previous transaction is in the shadow list
            wait (sent_cnt == queued_cnt);
            pending_requests.push_back(next_random_request(phase == 3));
            queued_cnt++;
         end
         wait (sent_cnt == queued_cnt && expected_grants.size() == 0);
      end

      // Catch anything the block emits late
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: page_frame_free_list_allocator_top.f
src/pffl_pkg.sv
src/pffl_ctrl.sv
src/pffl_datapath.sv
src/page_frame_free_list_allocator_top.sv
tb/testbench.sv
